// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, switched off while reset is high
`define WBPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that is also checked across reset
`define WBPS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/wbps_pkg.sv =====
`default_nettype none

package wbps_pkg;

   localparam int WIN_DEPTH       = 32;
   localparam int IDX_W           = $clog2(WIN_DEPTH);
   localparam int DEF_MAX_PATTERN = 32;
   localparam int BYTE_W          = 8;
   localparam int ADDR_W          = 64;
   localparam int LEN_W           = 6;
   localparam int SKIP_W          = 5;
   localparam int CSR_W           = 64;
   localparam int CSR_IDX_W       = 3;
   localparam int REQ_DATA_W      = 72;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LO     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_MID_LO = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_MID_HI = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_HI     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CARE       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN        = 3'd5;

   // signature as seen from the window: entry j lines up with window byte j (0 newest)
   typedef struct packed {
      logic [LEN_W-1:0]                   len;
      logic [WIN_DEPTH-1:0]               care;
      logic [WIN_DEPTH-1:0][BYTE_W-1:0]   pat;
   } sig_cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/wbps_sig_cfg.sv =====
`default_nettype none

module wbps_sig_cfg
   import wbps_pkg::*;
#(
   parameter int CAPACITY = DEF_MAX_PATTERN
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_addr,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   output sig_cfg_type               sig_cfg
);

   logic [WIN_DEPTH-1:0][BYTE_W-1:0] pat_ff, pat_in;
   logic [WIN_DEPTH-1:0]             care_ff, care_in;
   logic [LEN_W-1:0]                 len_ff, len_in;
   logic [LEN_W-1:0]                 len_eff;

   always_comb begin
      pat_in  = pat_ff;
      care_in = care_ff;
      len_in  = len_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_PAT_LO:     pat_in[7:0]   = csr_wdata;
            CSR_PAT_MID_LO: pat_in[15:8]  = csr_wdata;
            CSR_PAT_MID_HI: pat_in[23:16] = csr_wdata;
            CSR_PAT_HI:     pat_in[31:24] = csr_wdata;
            CSR_CARE:       care_in       = csr_wdata[WIN_DEPTH-1:0];
            CSR_LEN:        len_in        = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         care_ff <= '0;
         len_ff  <= LEN_W'(1);
      end else begin
         pat_ff  <= pat_in;
         care_ff <= care_in;
         len_ff  <= len_in;
      end
   end

   // zero acts as one, oversize clamps to the window capacity
   always_comb begin
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_W'(CAPACITY)) begin
         len_eff = LEN_W'(CAPACITY);
      end else begin
         len_eff = len_ff;
      end
   end

   // window byte j holds signature byte len-1-j at the moment of a match
   always_comb begin
      sig_cfg.len = len_eff;
      for (int j = 0; j < WIN_DEPTH; j++) begin
         logic [LEN_W-1:0] k;
         k = len_eff - LEN_W'(1) - LEN_W'(j);
         if (LEN_W'(j) < len_eff) begin
            sig_cfg.care[j] = care_ff[k[IDX_W-1:0]];
            sig_cfg.pat[j]  = pat_ff[k[IDX_W-1:0]];
         end else begin
            sig_cfg.care[j] = 1'b0;
            sig_cfg.pat[j]  = '0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/wbps_match.sv =====
`default_nettype none

module wbps_match
   import wbps_pkg::*;
#(
   parameter int CAPACITY = DEF_MAX_PATTERN
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic              region_start,
   input  wire sig_cfg_type       sig_cfg,
   output logic                   hit
);

   localparam int FILL_W = $clog2(CAPACITY + 1);

   logic [CAPACITY-1:0][BYTE_W-1:0] window_ff, window_in;
   logic [FILL_W-1:0]               fill_ff, fill_in;
   logic [SKIP_W-1:0]               skip_ff, skip_in, skip_cur;
   logic [CAPACITY-1:0]             byte_ok;

   always_comb begin
      window_in[0] = data_byte;
      for (int j = 1; j < CAPACITY; j++) begin
         window_in[j] = region_start ? '0 : window_ff[j-1];
      end

      if (region_start) begin
         fill_in = FILL_W'(1);
      end else if (fill_ff < FILL_W'(CAPACITY)) begin
         fill_in = fill_ff + FILL_W'(1);
      end else begin
         fill_in = fill_ff;
      end

      skip_cur = region_start ? '0 : skip_ff;

      for (int j = 0; j < CAPACITY; j++) begin
         byte_ok[j] = !sig_cfg.care[j] || (window_in[j] == sig_cfg.pat[j]);
      end

      hit = (skip_cur == '0) && (LEN_W'(fill_in) >= sig_cfg.len) && (&byte_ok);

      // a match blocks the next len-1 bytes of the same region from ending another one
      if (hit) begin
         skip_in = SKIP_W'(sig_cfg.len - LEN_W'(1));
      end else if (skip_cur != '0) begin
         skip_in = skip_cur - SKIP_W'(1);
      end else begin
         skip_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         skip_ff <= '0;
      end else if (advance) begin
         fill_ff <= fill_in;
         skip_ff <= skip_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/wildcard_byte_pattern_scanner_unit.sv =====
// an accepted byte is held in the input stage; its match is registered in the result register for rsp_tvalid
// throughput: one byte per cycle unless the result stalls; the window shift and masked compare run in a single stage
// a stalled result register holds the input stage, which then takes no more than one byte
// reset (synchronous, active high) empties both stages, clears window fill and skip count,
// and returns pattern, care mask and length registers to zero, zero and one
`default_nettype none

module wildcard_byte_pattern_scanner_unit
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // data_byte, byte_address
   input  wire logic                  req_tuser,  // region_start
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [ADDR_W-1:0]          rsp_tdata,  // match_address
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [CSR_W-1:0]      csr_wdata
);

   localparam int CAPACITY = (MAX_PATTERN < WIN_DEPTH) ? MAX_PATTERN : WIN_DEPTH;

   sig_cfg_type       sig_cfg;
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_data_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s1_start_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic              out_free, advance, accept, hit;

   wbps_sig_cfg #(
      .CAPACITY (CAPACITY)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .sig_cfg   (sig_cfg)
   );

   wbps_match #(
      .CAPACITY (CAPACITY)
   ) u_match (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .data_byte    (s1_data_ff),
      .region_start (s1_start_ff),
      .sig_cfg      (sig_cfg),
      .hit          (hit)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = hit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff  <= req_tdata[BYTE_W-1:0];
         s1_addr_ff  <= req_tdata[BYTE_W +: ADDR_W];
         s1_start_ff <= req_tuser;
      end
   end

   // match starts len-1 bytes before the byte that completes it
   always_ff @(posedge clock) begin
      if (advance && hit) begin
         rsp_addr_ff <= s1_addr_ff - ADDR_W'(sig_cfg.len - LEN_W'(1));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/wbps_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module wbps_checker
   import wbps_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [ADDR_W-1:0]     rsp_tdata
);

   // a waiting result keeps its address
   `WBPS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp transfer dropped or changed while stalled")

   // reset empties the result register
   `WBPS_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid, "rsp_tvalid high after reset")

   // a free result register never blocks the input side
   `WBPS_ASSERT_ALWAYS(a_req_flow, clock, (!rsp_tvalid || rsp_tready) |-> req_tready, "input stalled while result side is free")

   // a fresh result comes from a byte taken into the input stage, then passed on to the result register
   `WBPS_ASSERT(a_rsp_source, clock, reset, $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2), "result without a matching req transfer")

endmodule

bind wildcard_byte_pattern_scanner_unit wbps_checker u_wbps_checker (.*);

`default_nettype wire
